### sv/modulation_matrix_accumulator_unit_defines.svh
// assertion macros shared by the modulation matrix accumulator
`ifndef MODULATION_MATRIX_ACCUMULATOR_UNIT_DEFINES_SVH
`define MODULATION_MATRIX_ACCUMULATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// condition must never hold at a clock edge
`define MMACC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion failed: condition must never hold");
// antecedent in one cycle implies consequent in the next
`define MMACC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MMACC_ASSERT_NEVER(lbl, clk, rstn, cond)
`define MMACC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### sv/mmacc_pkg.sv
`timescale 1ns / 1ps
package mmacc_pkg;

  localparam int NUM_SLOTS   = 32;
  localparam int NUM_SOURCES = 16;
  localparam int NUM_DESTS   = 16;

  localparam int SLOT_W = 5;
  localparam int SRC_W  = 4;
  localparam int DEST_W = 4;
  localparam int VAL_W  = 16;
  localparam int ACT_W  = 3;

  // q1.15 fixed point
  localparam int Q_FRAC  = 15;
  localparam int ONE_Q15 = 32768;

  // datapath widths: bipolar term, product, accumulator
  localparam int TERM_W = VAL_W + 2;
  localparam int PROD_W = TERM_W + VAL_W;
  localparam int ACC_W  = 40;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;

  // input action codes
  localparam logic [ACT_W-1:0] ACT_ADD        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_UPDATE     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_SOURCE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET_BASE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PROCESS    = 3'd5;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_UPDATE,
    OP_SET_SOURCE,
    OP_SET_BASE,
    OP_PROCESS
  } op_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [SLOT_W-1:0]       slot;
    logic [DEST_W-1:0]       destination;
    logic [SRC_W-1:0]        source;
    logic signed [VAL_W-1:0] depth;
    logic                    bipolar;
    logic [VAL_W-1:0]        sample_value;
  } in_item_t;

  typedef struct packed {
    logic [DEST_W-1:0] out_destination;
    logic [VAL_W-1:0]  mod_value;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_e                     op;
    logic [SLOT_W-1:0]       slot;
    logic [DEST_W-1:0]       dest;
    logic [SRC_W-1:0]        source;
    logic signed [VAL_W-1:0] depth;
    logic                    bipolar;
    logic [VAL_W-1:0]        value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

### sv/mmacc_front.sv
`timescale 1ns / 1ps
module mmacc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  mmacc_pkg::in_item_t item_i,
  input  mmacc_pkg::qstat_t   qstat_i,
  output logic                cmd_push_o,
  output mmacc_pkg::cmd_t     cmd_o
);
  import mmacc_pkg::*;

  logic valid_q;
  cmd_t cmd_q;
  logic can_load;
  logic accept;
  logic known;
  op_e  op_dec;

  assign cmd_push_o = valid_q && !qstat_i.full;
  assign can_load   = !valid_q || !qstat_i.full;
  assign full_o     = !can_load;
  assign accept     = push_i && can_load;
  assign cmd_o      = cmd_q;

  // classify the action; unused codes are dropped here
  always_comb begin
    known  = 1'b1;
    op_dec = OP_PROCESS;
    unique case (item_i.action)
      ACT_ADD:        op_dec = OP_ADD;
      ACT_REMOVE:     op_dec = OP_REMOVE;
      ACT_UPDATE:     op_dec = OP_UPDATE;
      ACT_SET_SOURCE: op_dec = OP_SET_SOURCE;
      ACT_SET_BASE:   op_dec = OP_SET_BASE;
      ACT_PROCESS:    op_dec = OP_PROCESS;
      default:        known  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= known;
    end else if (cmd_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op      <= op_dec;
      cmd_q.slot    <= item_i.slot;
      cmd_q.dest    <= item_i.destination;
      cmd_q.source  <= item_i.source;
      cmd_q.depth   <= item_i.depth;
      cmd_q.bipolar <= item_i.bipolar;
      cmd_q.value   <= item_i.sample_value;
    end
  end

endmodule

### sv/mmacc_cmd_fifo.sv
`timescale 1ns / 1ps
module mmacc_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mmacc_pkg::cmd_t   cmd_i,
  input  logic              pop_i,
  output mmacc_pkg::cmd_t   cmd_o,
  output mmacc_pkg::qstat_t qstat_o
);
  import mmacc_pkg::*;

  cmd_t                 entry_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q;
  logic [CMD_PTR_W-1:0] rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign cmd_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### sv/mmacc_back.sv
`timescale 1ns / 1ps
module mmacc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mmacc_pkg::cmd_t      cmd_i,
  input  mmacc_pkg::qstat_t    qstat_i,
  output logic                 cmd_pop_o,
  output mmacc_pkg::out_item_t result_o,
  output logic                 result_valid_o,
  input  logic                 result_pop_i
);
  import mmacc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_EMIT} state_e;

  localparam logic signed [TERM_W-1:0] TERM_ONE  = TERM_W'(ONE_Q15);
  localparam logic signed [ACC_W-1:0]  SAT_LIMIT = ACC_W'(ONE_Q15) << Q_FRAC;

  state_e state_q;

  // routing table and level stores
  logic [NUM_SLOTS-1:0]    slot_valid_q;
  logic [NUM_SLOTS-1:0]    slot_bip_q;
  logic [SRC_W-1:0]        slot_source_q [NUM_SLOTS];
  logic [DEST_W-1:0]       slot_dest_q   [NUM_SLOTS];
  logic signed [VAL_W-1:0] slot_depth_q  [NUM_SLOTS];
  logic [VAL_W-1:0]        source_level_q [NUM_SOURCES];
  logic [VAL_W-1:0]        dest_base_q    [NUM_DESTS];
  logic [NUM_DESTS-1:0]    dest_present_q;

  // per-destination sums
  logic signed [ACC_W-1:0] acc_q [NUM_DESTS];

  logic [SLOT_W-1:0] walk_idx_q;
  logic [DEST_W-1:0] emit_idx_q;

  // term and product stages
  logic                     s1_valid_q;
  logic [DEST_W-1:0]        s1_dest_q;
  logic signed [TERM_W-1:0] s1_term_q;
  logic signed [VAL_W-1:0]  s1_depth_q;
  logic                     p_valid_q;
  logic [DEST_W-1:0]        p_dest_q;
  logic signed [PROD_W-1:0] p_prod_q;

  out_item_t result_q;
  logic      result_valid_q;

  logic                     take;
  logic                     slot_match;
  logic                     wr_add;
  logic                     wr_remove;
  logic                     wr_update;
  logic                     wr_source;
  logic                     wr_base;
  logic                     start_proc;
  logic [SLOT_W-1:0]        rd_slot;
  logic [VAL_W-1:0]         level;
  logic signed [TERM_W-1:0] term;
  logic                     issue;
  logic [DEST_W-1:0]        acc_idx;
  logic signed [ACC_W-1:0]  acc_rd;
  logic signed [ACC_W-1:0]  total;
  logic [VAL_W-1:0]         mod_value;
  logic                     out_free;
  logic                     emit_fire;
  logic                     emit_step;
  logic                     emit_last;
  logic signed [PROD_W-1:0] prod;

  assign take       = (state_q == ST_IDLE) && !qstat_i.empty;
  assign cmd_pop_o  = take;
  assign rd_slot    = (state_q == ST_IDLE) ? cmd_i.slot : walk_idx_q;
  assign slot_match = slot_valid_q[rd_slot] && (slot_dest_q[rd_slot] == cmd_i.dest);

  always_comb begin
    wr_add     = 1'b0;
    wr_remove  = 1'b0;
    wr_update  = 1'b0;
    wr_source  = 1'b0;
    wr_base    = 1'b0;
    start_proc = 1'b0;
    if (take) begin
      unique case (cmd_i.op)
        OP_ADD:        wr_add     = 1'b1;
        OP_REMOVE:     wr_remove  = slot_match;
        OP_UPDATE:     wr_update  = slot_match;
        OP_SET_SOURCE: wr_source  = 1'b1;
        OP_SET_BASE:   wr_base    = 1'b1;
        OP_PROCESS:    start_proc = 1'b1;
        default:       start_proc = 1'b0;
      endcase
    end
  end

  // source term, bipolar maps s to 2s - 1
  assign level = source_level_q[slot_source_q[rd_slot]];
  assign term  = slot_bip_q[rd_slot] ? ($signed({1'b0, level, 1'b0}) - TERM_ONE)
                                     : $signed({2'b00, level});
  assign issue = (state_q == ST_WALK);
  assign prod  = PROD_W'(s1_term_q) * PROD_W'(s1_depth_q);

  // one read port on the sums: walk pipeline or emit
  assign acc_idx = (state_q == ST_EMIT) ? emit_idx_q : p_dest_q;
  assign acc_rd  = acc_q[acc_idx];
  assign total   = acc_rd + $signed({{(ACC_W-VAL_W-Q_FRAC){1'b0}}, dest_base_q[emit_idx_q],
                                     {Q_FRAC{1'b0}}});

  always_comb begin
    if (total[ACC_W-1] || (total == '0)) begin
      mod_value = '0;
    end else if (total >= SAT_LIMIT) begin
      mod_value = VAL_W'(ONE_Q15);
    end else begin
      mod_value = total[Q_FRAC +: VAL_W];
    end
  end

  assign out_free  = !result_valid_q || result_pop_i;
  assign emit_fire = (state_q == ST_EMIT) && dest_present_q[emit_idx_q] && out_free;
  assign emit_step = (state_q == ST_EMIT) && (!dest_present_q[emit_idx_q] || out_free);
  assign emit_last = ((dest_present_q >> emit_idx_q) == NUM_DESTS'(1));

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      walk_idx_q     <= '0;
      emit_idx_q     <= '0;
      s1_valid_q     <= 1'b0;
      p_valid_q      <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      s1_valid_q <= issue && slot_valid_q[rd_slot];
      p_valid_q  <= s1_valid_q;
      if (emit_fire) begin
        result_valid_q           <= 1'b1;
        result_q.out_destination <= emit_idx_q;
        result_q.mod_value       <= mod_value;
        result_q.last            <= emit_last;
      end else if (result_pop_i) begin
        result_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_proc) begin
            walk_idx_q <= '0;
            state_q    <= ST_WALK;
          end
        end
        ST_WALK: begin
          walk_idx_q <= walk_idx_q + 1'b1;
          if (walk_idx_q == SLOT_W'(NUM_SLOTS-1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid_q && !p_valid_q) begin
            emit_idx_q <= '0;
            state_q    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            emit_idx_q <= emit_idx_q + 1'b1;
            if (emit_idx_q == DEST_W'(NUM_DESTS-1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q   <= '0;
      dest_present_q <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        source_level_q[i] <= '0;
      end
      for (int i = 0; i < NUM_DESTS; i++) begin
        dest_base_q[i] <= '0;
      end
    end else begin
      if (wr_add) begin
        slot_valid_q[cmd_i.slot]   <= 1'b1;
        dest_present_q[cmd_i.dest] <= 1'b1;
      end
      if (wr_remove) begin
        slot_valid_q[cmd_i.slot] <= 1'b0;
      end
      if (wr_source) begin
        source_level_q[cmd_i.source] <= cmd_i.value;
      end
      if (wr_base) begin
        dest_base_q[cmd_i.dest] <= cmd_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_add) begin
      slot_source_q[cmd_i.slot] <= cmd_i.source;
      slot_dest_q[cmd_i.slot]   <= cmd_i.dest;
      slot_bip_q[cmd_i.slot]    <= cmd_i.bipolar;
    end
    if (wr_add || wr_update) begin
      slot_depth_q[cmd_i.slot] <= cmd_i.depth;
    end
    s1_dest_q  <= slot_dest_q[rd_slot];
    s1_term_q  <= term;
    s1_depth_q <= slot_depth_q[rd_slot];
    p_dest_q   <= s1_dest_q;
    p_prod_q   <= prod;
    if (start_proc) begin
      for (int i = 0; i < NUM_DESTS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (p_valid_q) begin
      acc_q[acc_idx] <= acc_rd + ACC_W'(p_prod_q);
    end
  end

endmodule

### sv/modulation_matrix_accumulator_unit.sv
`timescale 1ns / 1ps
// modulation matrix accumulator: a 32-slot routing table maps 16 sources onto
// 16 destinations with a signed q1.15 depth each. items enter through a
// queue-style port (push/full) and results leave through one (empty/pop).
// add, remove, update, set source and set base items change state and give no
// result; a process item gives one result per destination that ever had a
// routing, in ascending order, with last set on the final one. a front stage
// decodes each item into a command, a four-entry command queue decouples it
// from the back end, and the back end owns the tables. state-changing items
// are applied by the back end while it is idle. a process item walks
// all 32 slots through a term/multiply/accumulate pipeline (one slot per
// cycle, then a drain of that pipeline), then steps over the 16 destinations
// (one per cycle, longer when results are not popped).
module modulation_matrix_accumulator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  mmacc_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output mmacc_pkg::out_item_t out_item_o
);
  import mmacc_pkg::*;

`include "modulation_matrix_accumulator_unit_defines.svh"

  cmd_t   front_cmd;
  cmd_t   queue_cmd;
  logic   cmd_push;
  logic   cmd_pop;
  qstat_t qstat;
  logic   result_valid;

  // decode stage, holds one command while the queue is full
  mmacc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (in_item_i),
    .qstat_i    (qstat),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  // command queue between decode and execution
  mmacc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .pop_i   (cmd_pop),
    .cmd_o   (queue_cmd),
    .qstat_o (qstat)
  );

  // tables, accumulation pipeline and result register
  mmacc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (queue_cmd),
    .qstat_i        (qstat),
    .cmd_pop_o      (cmd_pop),
    .result_o       (out_item_o),
    .result_valid_o (result_valid),
    .result_pop_i   (pop)
  );

  assign empty = !result_valid;

  // back end only takes commands that are in the queue
  `MMACC_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, cmd_pop && qstat.empty)
  // decode stage never writes a full queue
  `MMACC_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, cmd_push && qstat.full)
  // a write without a read leaves the queue non-empty
  `MMACC_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, cmd_push && !cmd_pop, !qstat.empty)
  // a waiting result not taken is still there next cycle
  `MMACC_ASSERT_NEXT(a_result_held, clk_i, rst_ni, result_valid && !pop, result_valid)

endmodule

### bench/tb_modulation_matrix_accumulator_unit.sv
`timescale 1ns / 1ps
module tb_modulation_matrix_accumulator_unit;
  import mmacc_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int RANDOM_ITEMS    = 400;
  localparam int PRESSURE_ITEMS  = 10;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int TAIL_CYCLES     = 120;

  // action codes the block decodes as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  modulation_matrix_accumulator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the routing table and level registers
  bit                    route_valid   [NUM_SLOTS];
  bit [SRC_W-1:0]        route_src     [NUM_SLOTS];
  bit [DEST_W-1:0]       route_dest    [NUM_SLOTS];
  bit signed [VAL_W-1:0] route_depth   [NUM_SLOTS];
  bit                    route_bipolar [NUM_SLOTS];
  bit [VAL_W-1:0]        src_level     [NUM_SOURCES];
  bit [VAL_W-1:0]        base_level    [NUM_DESTS];
  bit                    dest_live     [NUM_DESTS];

  out_item_t mod_results_q[$];

  bit idle_enable     = 1'b1;
  int rx_hold_req     = 0;
  int items_sent      = 0;
  int process_items   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int full_stalls     = 0;
  int quiet_cycles    = 0;

  out_item_t got_item;
  out_item_t want_item;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [VAL_W-1:0] mix_level(int d);
    longint acc;
    longint term;
    acc = longint'(base_level[d]) * ONE_Q15;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (route_valid[k] && route_dest[k] == d) begin
        term = longint'(src_level[route_src[k]]);
        if (route_bipolar[k]) term = 2 * term - ONE_Q15;
        acc += term * longint'(route_depth[k]);
      end
    end
    if (acc <= 0) return '0;
    if (acc >= longint'(ONE_Q15) * ONE_Q15) return VAL_W'(ONE_Q15);
    return VAL_W'(acc >> Q_FRAC);
  endfunction

  task automatic predict_item(input in_item_t item);
    out_item_t r;
    int        top;
    case (item.action)
      ACT_ADD: begin
        route_valid[item.slot]   = 1'b1;
        route_src[item.slot]     = item.source;
        route_dest[item.slot]    = item.destination;
        route_depth[item.slot]   = item.depth;
        route_bipolar[item.slot] = item.bipolar;
        dest_live[item.destination] = 1'b1;
      end
      ACT_REMOVE: begin
        if (route_valid[item.slot] && route_dest[item.slot] == item.destination)
          route_valid[item.slot] = 1'b0;
      end
      ACT_UPDATE: begin
        if (route_valid[item.slot] && route_dest[item.slot] == item.destination)
          route_depth[item.slot] = item.depth;
      end
      ACT_SET_SOURCE: src_level[item.source] = item.sample_value;
      ACT_SET_BASE:   base_level[item.destination] = item.sample_value;
      ACT_PROCESS: begin
        process_items++;
        top = -1;
        for (int d = 0; d < NUM_DESTS; d++)
          if (dest_live[d]) top = d;
        for (int d = 0; d < NUM_DESTS; d++) begin
          if (dest_live[d]) begin
            r.out_destination = DEST_W'(d);
            r.mod_value       = mix_level(d);
            r.last            = (d == top);
            mod_results_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // push stays high across back-to-back items
  task automatic send_item(input in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_item(item);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (mod_results_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic [ACT_W-1:0] action, int slot, int dest,
                                         int src, int depth, bit bip, int value);
    in_item_t it;
    it.action       = action;
    it.slot         = SLOT_W'(slot);
    it.destination  = DEST_W'(dest);
    it.source       = SRC_W'(src);
    it.depth        = VAL_W'(depth);
    it.bipolar      = bip;
    it.sample_value = VAL_W'(value);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       start;
    int       k;
    bit       found;
    it.slot        = SLOT_W'($urandom);
    it.destination = DEST_W'($urandom);
    it.source      = SRC_W'($urandom);
    it.bipolar     = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 60) it.depth = VAL_W'($urandom_range(0, 16384) - 8192);
    else if (r < 85) it.depth = VAL_W'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0: it.depth = 16'sh8000;
        1: it.depth = 16'sh7fff;
        2: it.depth = '0;
        default: it.depth = '1;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 80) it.sample_value = VAL_W'($urandom_range(0, ONE_Q15));
    else if (r < 90) it.sample_value = $urandom_range(0, 1) ? VAL_W'(ONE_Q15) : '0;
    else it.sample_value = VAL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 24) it.action = ACT_ADD;
    else if (r < 34) it.action = ACT_REMOVE;
    else if (r < 44) it.action = ACT_UPDATE;
    else if (r < 58) it.action = ACT_SET_SOURCE;
    else if (r < 68) it.action = ACT_SET_BASE;
    else if (r < 95) it.action = ACT_PROCESS;
    else it.action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    // most removes and updates aim at a live slot with its own destination
    if ((it.action == ACT_REMOVE || it.action == ACT_UPDATE) &&
        $urandom_range(0, 99) < 70) begin
      start = $urandom_range(0, NUM_SLOTS - 1);
      found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        k = (start + i) % NUM_SLOTS;
        if (!found && route_valid[k]) begin
          found          = 1'b1;
          it.slot        = SLOT_W'(k);
          it.destination = route_dest[k];
        end
      end
    end
    return it;
  endfunction

  // nothing routed yet, spare actions do nothing
  task automatic test_idle_table();
    send_item(make_item(ACT_PROCESS, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_SPARE_LO, 31, 15, 15, -1, 1, 65535));
    send_item(make_item(ACT_SPARE_HI, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_PROCESS, 31, 15, 15, -1, 1, 65535));
  endtask

  // field extremes, both clamps, bipolar mapping, levels above full scale
  task automatic test_routing_extremes();
    send_item(make_item(ACT_SET_SOURCE, 0, 0, 0, 0, 0, ONE_Q15));
    send_item(make_item(ACT_SET_SOURCE, 0, 0, 15, 0, 0, 65535));
    send_item(make_item(ACT_SET_BASE, 0, 15, 0, 0, 0, 65535));
    send_item(make_item(ACT_SET_BASE, 0, 7, 0, 0, 0, 16384));
    send_item(make_item(ACT_ADD, 0, 0, 0, 32767, 0, 0));
    send_item(make_item(ACT_ADD, 31, 15, 15, -32768, 1, 0));
    send_item(make_item(ACT_ADD, 1, 7, 0, 16384, 1, 0));
    send_item(make_item(ACT_ADD, 2, 7, 3, -1, 1, 0));
    send_item(make_item(ACT_PROCESS, 0, 0, 0, 0, 0, 0));
  endtask

  // destination match on remove and update, overwrite, emptied destination
  task automatic test_slot_commands();
    send_item(make_item(ACT_REMOVE, 1, 8, 0, 0, 0, 0));
    send_item(make_item(ACT_UPDATE, 5, 0, 0, 1234, 0, 0));
    send_item(make_item(ACT_UPDATE, 1, 7, 0, 8192, 0, 0));
    send_item(make_item(ACT_ADD, 0, 3, 15, 4096, 0, 0));
    send_item(make_item(ACT_REMOVE, 31, 15, 0, 0, 0, 0));
    send_item(make_item(ACT_REMOVE, 31, 15, 0, 0, 0, 0));
    send_item(make_item(ACT_PROCESS, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    in_item_t item;
    int       issued;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      // a stretch with no idling on either side
      if (issued == 150) idle_enable = 1'b0;
      if (issued == 220) idle_enable = 1'b1;
      if (issued == 300) wait_results_drained();
      item = random_item();
      send_item(item);
      if (item.action <= ACT_PROCESS) issued++;
    end
  endtask

  // receiver stalls while process items pile up, then the sender waits it out
  task automatic test_output_backpressure();
    rx_hold_req = RX_HOLD_CYCLES;
    for (int i = 0; i < PRESSURE_ITEMS; i++)
      send_item(make_item(ACT_PROCESS, $urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), $urandom));
    wait_results_drained();
  endtask

  initial begin : result_pacing
    int gap_cnt;
    gap_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        pop <= 1'b0;
        repeat (rx_hold_req) @(posedge clk_i);
        rx_hold_req = 0;
      end else if (gap_cnt > 0) begin
        pop <= 1'b0;
        gap_cnt--;
      end else begin
        pop <= 1'b1;
        gap_cnt = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      got_item = out_item;
      if (mod_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual dest %0d value %0d last %0b",
                 $time, got_item.out_destination, got_item.mod_value, got_item.last);
      end else begin
        want_item = mod_results_q.pop_front();
        results_checked++;
        if (got_item.out_destination !== want_item.out_destination ||
            got_item.mod_value !== want_item.mod_value ||
            got_item.last !== want_item.last) begin
          mismatches++;
          $display("%0t: expected dest %0d value %0d last %0b, actual dest %0d value %0d last %0b",
                   $time, want_item.out_destination, want_item.mod_value, want_item.last,
                   got_item.out_destination, got_item.mod_value, got_item.last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full) full_stalls++;
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, mod_results_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : run_all
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_table();
    test_routing_extremes();
    test_slot_commands();
    test_random_traffic();
    test_output_backpressure();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered: %0d items incl. %0d process, %0d results compared, %0d mismatches",
             items_sent, process_items, results_checked, mismatches);
    $display("covered: %0d cycles with input held off by full, one long output stall",
             full_stalls);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
